[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the watchdog RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[rtl/mcwdg_pkg.sv]
// ---------------------------------------------------------------------------
// Multi-channel watchdog package
// Command codes, queue word type, back-end states and sizing constants.
// ---------------------------------------------------------------------------
package mcwdg_pkg;

    localparam int unsigned CHANNELS_DEF = 16;
    localparam int unsigned QDEPTH       = 2;

    localparam int unsigned MODE_W   = 3;
    localparam int unsigned CHAN_W   = 4;
    localparam int unsigned DATA_W   = 32;

    localparam logic [MODE_W-1:0] MODE_TICK      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RELOAD    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ENABLE    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DISABLE   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SET_LIMIT = 3'd4;

    localparam logic KIND_TIMEOUT = 1'b0;
    localparam logic KIND_SCAN    = 1'b1;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_RELOAD,
        OP_ENABLE,
        OP_DISABLE,
        OP_SET_LIMIT
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [CHAN_W-1:0]  channel;
        logic [DATA_W-1:0]  limit_value;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

endpackage

[rtl/mcwdg_front.sv]
// ---------------------------------------------------------------------------
// Watchdog command front end
// Accepts command words, decodes the mode and drops words that do nothing.
// ---------------------------------------------------------------------------
module mcwdg_front #(
    parameter int unsigned CHANNELS = mcwdg_pkg::CHANNELS_DEF
) (
    input  logic                          i_start,
    input  logic [mcwdg_pkg::MODE_W-1:0]  i_mode,
    input  logic [mcwdg_pkg::CHAN_W-1:0]  i_channel,
    input  logic [mcwdg_pkg::DATA_W-1:0]  i_limit_value,
    input  logic                          i_full,
    output logic                          o_busy,
    output logic                          o_push,
    output mcwdg_pkg::t_cmd               o_cmd
);
    import mcwdg_pkg::*;

    logic mode_ok;
    logic chan_ok;
    t_op  op;

    // Unknown modes, and channels beyond the array on words other than ticks, are discarded here.
    always_comb begin
        mode_ok = 1'b1;
        op      = OP_TICK;
        unique case (i_mode)
            MODE_TICK:      op = OP_TICK;
            MODE_RELOAD:    op = OP_RELOAD;
            MODE_ENABLE:    op = OP_ENABLE;
            MODE_DISABLE:   op = OP_DISABLE;
            MODE_SET_LIMIT: op = OP_SET_LIMIT;
            default:        mode_ok = 1'b0;
        endcase
    end

    assign chan_ok = (op == OP_TICK) || (int'(i_channel) < int'(CHANNELS));

    assign o_busy            = i_full;
    assign o_push            = i_start && !i_full && mode_ok && chan_ok;
    assign o_cmd.op          = op;
    assign o_cmd.channel     = i_channel;
    assign o_cmd.limit_value = i_limit_value;

endmodule

[rtl/mcwdg_queue.sv]
// ---------------------------------------------------------------------------
// Watchdog command queue
// Short FIFO that decouples command acceptance from execution.
// ---------------------------------------------------------------------------
module mcwdg_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mcwdg_pkg::t_cmd i_cmd,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output mcwdg_pkg::t_cmd o_head
);
    import mcwdg_pkg::*;

    localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QDEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QDEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QDEPTH);

    t_cmd             r_slot [QDEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

[rtl/mcwdg_back.sv]
// ---------------------------------------------------------------------------
// Watchdog execution back end
// Applies channel commands and runs the per-tick channel scan.
// ---------------------------------------------------------------------------
module mcwdg_back #(
    parameter int unsigned CHANNELS = mcwdg_pkg::CHANNELS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    input  mcwdg_pkg::t_cmd               i_head,
    output logic                          o_pop,
    output logic                          o_valid,
    output logic                          o_kind,
    output logic [mcwdg_pkg::CHAN_W-1:0]  o_expired_channel,
    output logic [mcwdg_pkg::DATA_W-1:0]  o_next_wait,
    output logic                          o_last
);
    import mcwdg_pkg::*;

    localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [AW-1:0] IDX_LAST = AW'(CHANNELS - 1);

    // Channel stores; the limit store is qualified by per-entry valid bits.
    logic [DATA_W-1:0] mem_reload [CHANNELS];
    logic [DATA_W-1:0] mem_limit  [CHANNELS];

    t_state              r_state,    n_state;
    logic [AW-1:0]       r_scan_idx, n_scan_idx;
    logic [DATA_W-1:0]   r_time,     n_time;
    logic [DATA_W-1:0]   r_best,     n_best;
    logic [CHANNELS-1:0] r_enabled,  n_enabled;
    logic [CHANNELS-1:0] r_lim_ok,   n_lim_ok;

    logic                r_ev_valid;
    logic                r_ev_en;
    logic [AW-1:0]       r_ev_idx;
    logic [DATA_W-1:0]   r_rd_reload;
    logic [DATA_W-1:0]   r_rd_limit;

    logic                r_valid,  n_valid;
    logic                r_kind,   n_kind;
    logic [CHAN_W-1:0]   r_chan,   n_chan;
    logic [DATA_W-1:0]   r_wait,   n_wait;
    logic                r_last,   n_last;

    logic                rd_en;
    logic                we_reload;
    logic [AW-1:0]       wa_reload;
    logic                we_limit;
    logic [AW-1:0]       cmd_idx;
    logic [DATA_W-1:0]   elapsed;
    logic [DATA_W-1:0]   remain;

    assign cmd_idx = AW'(i_head.channel);
    assign elapsed = r_time - r_rd_reload;
    assign remain  = r_rd_limit - elapsed;

    always_comb begin
        n_state    = r_state;
        n_scan_idx = r_scan_idx;
        n_time     = r_time;
        n_best     = r_best;
        n_enabled  = r_enabled;
        n_lim_ok   = r_lim_ok;
        n_valid    = 1'b0;
        n_kind     = KIND_TIMEOUT;
        n_chan     = '0;
        n_wait     = '0;
        n_last     = 1'b0;
        o_pop      = 1'b0;
        rd_en      = 1'b0;
        we_reload  = 1'b0;
        wa_reload  = r_ev_idx;
        we_limit   = 1'b0;

        // Evaluation of the channel read in the previous cycle.
        if (r_ev_valid && r_ev_en && (r_rd_limit != '0)) begin
            if (elapsed >= r_rd_limit) begin
                n_valid   = 1'b1;
                n_kind    = KIND_TIMEOUT;
                n_chan    = CHAN_W'(r_ev_idx);
                we_reload = 1'b1;
            end else if ((r_best == '0) || (remain < r_best)) begin
                n_best = remain;
            end
        end

        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop     = 1'b1;
                    wa_reload = cmd_idx;
                    unique case (i_head.op)
                        OP_TICK: begin
                            n_time     = r_time + 1'b1;
                            n_best     = '0;
                            n_scan_idx = '0;
                            n_state    = ST_SCAN;
                        end
                        OP_RELOAD: begin
                            we_reload = 1'b1;
                        end
                        OP_ENABLE: begin
                            n_enabled[cmd_idx] = 1'b1;
                            we_reload          = 1'b1;
                        end
                        OP_DISABLE: begin
                            n_enabled[cmd_idx] = 1'b0;
                        end
                        OP_SET_LIMIT: begin
                            n_lim_ok[cmd_idx] = 1'b1;
                            we_limit          = 1'b1;
                            we_reload         = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                rd_en = 1'b1;
                if (r_scan_idx == IDX_LAST) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_scan_idx = r_scan_idx + 1'b1;
                end
            end
            ST_DRAIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                n_valid = 1'b1;
                n_kind  = KIND_SCAN;
                n_wait  = r_best;
                n_last  = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_scan_idx <= '0;
            r_time     <= '0;
            r_best     <= '0;
            r_enabled  <= '0;
            r_lim_ok   <= '0;
            r_ev_valid <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_scan_idx <= n_scan_idx;
            r_time     <= n_time;
            r_best     <= n_best;
            r_enabled  <= n_enabled;
            r_lim_ok   <= n_lim_ok;
            r_ev_valid <= rd_en;
            r_valid    <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_chan   <= n_chan;
        r_wait   <= n_wait;
        r_last   <= n_last;
        r_ev_idx <= r_scan_idx;
        r_ev_en  <= r_enabled[r_scan_idx] && r_lim_ok[r_scan_idx];
    end

    // Channel memories: one write port each, one registered read port.
    always_ff @(posedge i_clk) begin
        if (we_reload) begin
            mem_reload[wa_reload] <= r_time;
        end
        if (we_limit) begin
            mem_limit[cmd_idx] <= i_head.limit_value;
        end
        if (rd_en) begin
            r_rd_reload <= mem_reload[r_scan_idx];
            r_rd_limit  <= mem_limit[r_scan_idx];
        end
    end

    assign o_valid           = r_valid;
    assign o_kind            = r_kind;
    assign o_expired_channel = r_chan;
    assign o_next_wait       = r_wait;
    assign o_last            = r_last;

endmodule

[rtl/multi_channel_watchdog.sv]
// ---------------------------------------------------------------------------
// Multi-channel watchdog timer
// Time counter with per-channel timeout detection and next-wait reporting.
// ---------------------------------------------------------------------------
// A word is taken on a rising edge where start is high and busy is low; busy
// rises only when the two-entry command queue is full. Results leave on the
// o_* ports, each for exactly one cycle while o_valid is high, and the
// receiver cannot stall them. A tick advances time by one and scans every
// channel in index order through a single read port on the channel memories,
// one channel per cycle: it occupies the execution side through the queue
// pop, the channel reads, an evaluation drain and the end-of-scan word. Each
// active channel whose elapsed time has reached its limit gives a timeout
// word and is reloaded; the scan then closes with an end-of-scan word
// (o_kind high, o_last high) carrying the least remaining time of the
// active channels that did not expire, or 0 if there is none. Reload,
// enable, disable and set-limit words are applied on pop and give no result.
// Words with an unknown mode, and non-tick words with a channel at or above
// CHANNELS, are discarded on entry. No clearing pass follows reset.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module multi_channel_watchdog #(
    parameter int unsigned CHANNELS = mcwdg_pkg::CHANNELS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [mcwdg_pkg::MODE_W-1:0]  i_mode,
    input  logic [mcwdg_pkg::CHAN_W-1:0]  i_channel,
    input  logic [mcwdg_pkg::DATA_W-1:0]  i_limit_value,
    output logic                          o_valid,
    output logic                          o_kind,
    output logic [mcwdg_pkg::CHAN_W-1:0]  o_expired_channel,
    output logic [mcwdg_pkg::DATA_W-1:0]  o_next_wait,
    output logic                          o_last
);
    import mcwdg_pkg::*;

    // Front end to queue, queue to back end.
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    t_cmd q_in;
    t_cmd q_head;

    mcwdg_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_start       (start),
        .i_mode        (i_mode),
        .i_channel     (i_channel),
        .i_limit_value (i_limit_value),
        .i_full        (q_full),
        .o_busy        (busy),
        .o_push        (q_push),
        .o_cmd         (q_in)
    );

    mcwdg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    mcwdg_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_empty           (q_empty),
        .i_head            (q_head),
        .o_pop             (q_pop),
        .o_valid           (o_valid),
        .o_kind            (o_kind),
        .o_expired_channel (o_expired_channel),
        .o_next_wait       (o_next_wait),
        .o_last            (o_last)
    );

    // An end-of-scan word always closes the run and names no channel.
    `ASSERT_IMPL(a_scan_word_form, i_clk, i_rst_n, o_valid && (o_kind == KIND_SCAN), o_last && (o_expired_channel == '0))

    // A timeout word carries no wait, is never last and names a real channel.
    `ASSERT_IMPL(a_timeout_word_form, i_clk, i_rst_n, o_valid && (o_kind == KIND_TIMEOUT), !o_last && (o_next_wait == '0) && (int'(o_expired_channel) < int'(CHANNELS)))

    // The next scan cannot produce a word in the cycle right after a scan ends.
    `ASSERT_NEXT(a_gap_after_scan, i_clk, i_rst_n, o_valid && o_last, !o_valid)

    // The queue only drains while it holds something.
    `ASSERT_IMPL(a_pop_not_empty, i_clk, i_rst_n, q_pop, !q_empty)

endmodule

[bench/mcwdg_tb_pkg.sv]
// ---------------------------------------------------------------------------
// Watchdog timeout scoreboard
// Tracks the channel timers of the multi-channel watchdog, works out the
// timeout and end-of-scan words that each accepted command causes, and
// checks the words that leave the block against them in order.
// ---------------------------------------------------------------------------
package mcwdg_tb_pkg;

    import mcwdg_pkg::*;

    // Highest code the mode field can carry; codes above MODE_SET_LIMIT are unused.
    localparam logic [MODE_W-1:0] MODE_CODE_MAX = 3'd7;

    typedef struct {
        logic              kind;
        logic [CHAN_W-1:0] channel;
        logic [DATA_W-1:0] next_wait;
        logic              last;
    } timer_event_t;

    class timeout_scoreboard;

        logic [DATA_W-1:0] ticks_now;
        logic [DATA_W-1:0] reloaded_at [CHANNELS_DEF];
        logic [DATA_W-1:0] limit_of    [CHANNELS_DEF];
        logic              enabled     [CHANNELS_DEF];
        timer_event_t      awaited_results [$];
        int unsigned       mismatches;

        function new();
            ticks_now  = '0;
            mismatches = 0;
            foreach (limit_of[c]) begin
                reloaded_at[c] = '0;
                limit_of[c]    = '0;
                enabled[c]     = 1'b0;
            end
        endfunction

        // Called for every command word the block takes in.
        function void take_command(logic [MODE_W-1:0] mode, logic [CHAN_W-1:0] chan,
                                   logic [DATA_W-1:0] lim);
            timer_event_t      ev;
            logic [DATA_W-1:0] elapsed;
            logic [DATA_W-1:0] remain;
            logic [DATA_W-1:0] best;
            if (mode == MODE_TICK) begin
                ticks_now = ticks_now + 1;
                best      = '0;
                for (int c = 0; c < CHANNELS_DEF; c++) begin
                    if (!enabled[c] || limit_of[c] == '0) continue;
                    elapsed = ticks_now - reloaded_at[c];
                    if (elapsed >= limit_of[c]) begin
                        ev.kind      = KIND_TIMEOUT;
                        ev.channel   = c[CHAN_W-1:0];
                        ev.next_wait = '0;
                        ev.last      = 1'b0;
                        awaited_results.push_back(ev);
                        reloaded_at[c] = ticks_now;
                    end else begin
                        remain = limit_of[c] - elapsed;
                        if (best == '0 || remain < best) best = remain;
                    end
                end
                ev.kind      = KIND_SCAN;
                ev.channel   = '0;
                ev.next_wait = best;
                ev.last      = 1'b1;
                awaited_results.push_back(ev);
            end else if (chan < CHANNELS_DEF) begin
                case (mode)
                    MODE_RELOAD: begin
                        reloaded_at[chan] = ticks_now;
                    end
                    MODE_ENABLE: begin
                        enabled[chan]     = 1'b1;
                        reloaded_at[chan] = ticks_now;
                    end
                    MODE_DISABLE: begin
                        enabled[chan] = 1'b0;
                    end
                    MODE_SET_LIMIT: begin
                        limit_of[chan]    = lim;
                        reloaded_at[chan] = ticks_now;
                    end
                    default: begin
                    end
                endcase
            end
        endfunction

        // Called for every word the block puts out.
        function void check_result(logic kind, logic [CHAN_W-1:0] chan,
                                   logic [DATA_W-1:0] next_wait, logic last);
            timer_event_t want;
            if (awaited_results.size() == 0) begin
                $error("unexpected word: kind %0d channel %0d next_wait %0d last %0d",
                       kind, chan, next_wait, last);
                mismatches++;
                return;
            end
            want = awaited_results.pop_front();
            if (kind !== want.kind) begin
                $error("o_kind: expected %0d, got %0d", want.kind, kind);
                mismatches++;
            end
            if (chan !== want.channel) begin
                $error("o_expired_channel: expected %0d, got %0d", want.channel, chan);
                mismatches++;
            end
            if (next_wait !== want.next_wait) begin
                $error("o_next_wait: expected %0d, got %0d", want.next_wait, next_wait);
                mismatches++;
            end
            if (last !== want.last) begin
                $error("o_last: expected %0d, got %0d", want.last, last);
                mismatches++;
            end
        endfunction

    endclass

endpackage

[bench/tb_multi_channel_watchdog.sv]
// ---------------------------------------------------------------------------
// Multi-channel watchdog testbench
// Drives command words into the watchdog (ticks, reloads, enables, disables,
// limit updates and unused mode codes) with random gaps, and checks every
// timeout and end-of-scan word against a scoreboard that tracks the timers.
// ---------------------------------------------------------------------------
module tb_multi_channel_watchdog;

    import mcwdg_pkg::*;
    import mcwdg_tb_pkg::*;

    // Number of checked command words in the directed part.
    localparam int unsigned DIRECTED_WORDS = 21;
    // Number of checked command words in the random part.
    localparam int unsigned RANDOM_WORDS = 100;
    // Cycles with neither an accepted word nor a result before the run is
    // declared hung. The limit is far above the longest a tick holds the back end
    // plus the longest sender gap, so this is many times the worst case.
    localparam int unsigned STALL_LIMIT  = 2000;
    // Quiet time after the last awaited word, enough for one more full scan.
    localparam int unsigned SETTLE_CYCLES = CHANNELS_DEF + 8;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [MODE_W-1:0]   i_mode;
    logic [CHAN_W-1:0]   i_channel;
    logic [DATA_W-1:0]   i_limit_value;
    logic                o_valid;
    logic                o_kind;
    logic [CHAN_W-1:0]   o_expired_channel;
    logic [DATA_W-1:0]   o_next_wait;
    logic                o_last;

    timeout_scoreboard   board;
    int unsigned         idle_cycles;
    int unsigned         words_sent;
    int unsigned         calm_left;

    multi_channel_watchdog dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_mode            (i_mode),
        .i_channel         (i_channel),
        .i_limit_value     (i_limit_value),
        .o_valid           (o_valid),
        .o_kind            (o_kind),
        .o_expired_channel (o_expired_channel),
        .o_next_wait       (o_next_wait),
        .o_last            (o_last)
    );

    // 8 time unit clock, low half first so the first rising edge is at 4.
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Everything the block does is observed here, at the rising edge. Results
    // are checked before a word accepted at the same edge is noted: a word
    // cannot produce a result at the edge that takes it in. A valid that is X
    // is treated as a result so that it shows up as a failure.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (o_valid !== 1'b0) begin
                board.check_result(o_kind, o_expired_channel, o_next_wait, o_last);
            end
            if (start && busy === 1'b0) begin
                board.take_command(i_mode, i_channel, i_limit_value);
            end
            if (o_valid !== 1'b0 || (start && busy === 1'b0)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("tb_multi_channel_watchdog NOT OK");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Gap after an accepted word. Most gaps are zero or short, a few are long,
    // and during a calm stretch there are none at all. While start is low the
    // payload ports carry noise that the block must ignore.
    task automatic pause_after_word();
        int unsigned gap;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (calm_left > 0) begin
            calm_left--;
            gap = 0;
        end else if (pick < 55) begin
            gap = 0;
        end else if (pick < 88) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(12, 40);
        end
        repeat (gap) begin
            @(negedge i_clk);
            start         <= 1'b0;
            i_mode        <= $urandom;
            i_channel     <= $urandom;
            i_limit_value <= $urandom;
        end
    endtask

    // Presents one word and holds it until the block takes it. When the
    // previous word had no gap, start simply stays high into this one.
    task automatic send_word(input logic [MODE_W-1:0] mode, input logic [CHAN_W-1:0] chan,
                             input logic [DATA_W-1:0] lim);
        @(negedge i_clk);
        start         <= 1'b1;
        i_mode        <= mode;
        i_channel     <= chan;
        i_limit_value <= lim;
        do @(posedge i_clk); while (busy !== 1'b0);
        // Unused mode codes are dropped by the block and do not count.
        if (mode <= MODE_SET_LIMIT) words_sent++;
        pause_after_word();
    endtask

    // Holds the sender off until every awaited word has come out. Waiting on
    // the falling edge keeps this clear of the scoreboard update at the
    // rising edge.
    task automatic hold_until_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (board.awaited_results.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        int unsigned       pick;
        logic [CHAN_W-1:0] chan;
        logic [DATA_W-1:0] lim;
        bit                swept_all;

        board         = new();
        idle_cycles   = 0;
        words_sent    = 0;
        calm_left     = 0;
        swept_all     = 1'b0;
        start         = 1'b0;
        i_mode        = MODE_TICK;
        i_channel     = '0;
        i_limit_value = '0;
        i_rst_n       = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ------------------------------------------------------------------
        // Directed part.
        // ------------------------------------------------------------------
        // Nothing armed yet: the scan closes with a next wait of zero.
        send_word(MODE_TICK, '0, '0);
        // Channel 0 with the shortest limit expires on every tick; channel 15
        // with the longest limit never does and sets the next wait.
        send_word(MODE_SET_LIMIT, 4'd0, 32'd1);
        send_word(MODE_ENABLE, 4'd0, '0);
        send_word(MODE_SET_LIMIT, 4'd15, 32'hFFFF_FFFF);
        send_word(MODE_ENABLE, 4'd15, '0);
        send_word(MODE_TICK, '0, '0);
        // A mid-sized limit on channel 5, then channel 0 is switched off.
        send_word(MODE_SET_LIMIT, 4'd5, 32'd3);
        send_word(MODE_ENABLE, 4'd5, '0);
        send_word(MODE_DISABLE, 4'd0, '0);
        send_word(MODE_TICK, '0, '0);
        // A reload restarts channel 5 from the current time; time itself
        // does not move, so the next expiry comes three ticks later.
        send_word(MODE_RELOAD, 4'd5, '0);
        send_word(MODE_TICK, '0, '0);
        send_word(MODE_TICK, '0, '0);
        send_word(MODE_TICK, '0, '0);
        // A zero limit turns channel 15 inactive although it stays enabled.
        send_word(MODE_SET_LIMIT, 4'd15, '0);
        // A tick ignores its channel and limit fields, even when all ones.
        send_word(MODE_TICK, 4'd15, 32'hFFFF_FFFF);
        // Unused mode codes are dropped without a result.
        for (int m = MODE_SET_LIMIT + 1; m <= MODE_CODE_MAX; m++) begin
            send_word(m[MODE_W-1:0], $urandom, $urandom);
        end
        // Channel 0 kept its limit while disabled; enabling it reloads it.
        send_word(MODE_ENABLE, 4'd0, '0);
        send_word(MODE_TICK, '0, '0);
        send_word(MODE_SET_LIMIT, 4'd10, 32'h5555_5555);
        send_word(MODE_ENABLE, 4'd10, '0);
        send_word(MODE_TICK, '0, '0);

        // Let everything drain before the random part starts.
        hold_until_drained();

        // ------------------------------------------------------------------
        // Random part. Limits are mostly small so that channels expire often;
        // a few are zero, all ones or fully random.
        // ------------------------------------------------------------------
        while (words_sent < DIRECTED_WORDS + RANDOM_WORDS) begin
            pick = $urandom_range(0, 99);
            chan = $urandom_range(0, CHANNELS_DEF - 1);
            if (calm_left == 0 && $urandom_range(0, 9) == 0) begin
                calm_left = $urandom_range(8, 24);
            end
            if (!swept_all && words_sent >= DIRECTED_WORDS + 40) begin
                // Arm every channel with a limit of one, so the next ticks
                // time out all channels and give the longest result runs.
                swept_all = 1'b1;
                for (int c = 0; c < CHANNELS_DEF; c++) begin
                    send_word(MODE_SET_LIMIT, c[CHAN_W-1:0], 32'd1);
                end
                for (int c = 0; c < CHANNELS_DEF; c++) begin
                    send_word(MODE_ENABLE, c[CHAN_W-1:0], $urandom);
                end
                send_word(MODE_TICK, $urandom, $urandom);
                send_word(MODE_TICK, $urandom, $urandom);
            end else if (pick < 35) begin
                send_word(MODE_TICK, $urandom, $urandom);
            end else if (pick < 50) begin
                case ($urandom_range(0, 9))
                    0:       lim = '0;
                    1:       lim = 32'hFFFF_FFFF;
                    2, 3:    lim = $urandom;
                    default: lim = $urandom_range(1, 8);
                endcase
                send_word(MODE_SET_LIMIT, chan, lim);
                if ($urandom_range(0, 2) != 0) send_word(MODE_ENABLE, chan, $urandom);
            end else if (pick < 60) begin
                send_word(MODE_ENABLE, chan, $urandom);
            end else if (pick < 68) begin
                send_word(MODE_DISABLE, chan, $urandom);
            end else if (pick < 78) begin
                send_word(MODE_RELOAD, chan, $urandom);
            end else if (pick < 83) begin
                send_word($urandom_range(MODE_SET_LIMIT + 1, MODE_CODE_MAX), chan, $urandom);
            end else if (pick < 97) begin
                repeat ($urandom_range(3, 6)) send_word(MODE_TICK, $urandom, $urandom);
            end else begin
                hold_until_drained();
            end
        end

        // ------------------------------------------------------------------
        // End of run: drain, wait out one more scan for stray words, report.
        // ------------------------------------------------------------------
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (board.mismatches == 0 && board.awaited_results.size() == 0) begin
            $display("tb_multi_channel_watchdog OK");
        end else begin
            $display("tb_multi_channel_watchdog NOT OK");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/mcwdg_pkg.sv
rtl/mcwdg_front.sv
rtl/mcwdg_queue.sv
rtl/mcwdg_back.sv
rtl/multi_channel_watchdog.sv
bench/mcwdg_tb_pkg.sv
bench/tb_multi_channel_watchdog.sv
